@@ hw/rtl/hbwd_pkg.sv @@
// ----------------------------------------------------------------------------
// hbwd_pkg
// Types, codes and constants shared by the heartbeat watchdog modules.
// ----------------------------------------------------------------------------
`default_nettype none

package hbwd_pkg;

    localparam int CHANNELS_DEF = 8;
    localparam int CHANNEL_W    = 3;
    localparam int CH_MAX       = (1 << CHANNEL_W) - 1;
    localparam int CODE_W       = 8;
    localparam int TIME_W       = 32;
    localparam int CFG_W        = 16;
    localparam int APB_DW       = 32;
    localparam int APB_AW       = 3;

    localparam logic [CFG_W-1:0] STALL_TICKS_RST  = 16'd5;
    localparam logic [CFG_W-1:0] REPEAT_TICKS_RST = 16'd30;

    typedef enum logic [2:0] {
        CMD_TICK   = 3'd0,
        CMD_REG    = 3'd1,
        CMD_UNREG  = 3'd2,
        CMD_BEAT   = 3'd3,
        CMD_PARK   = 3'd4,
        CMD_WAIT   = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_LINE   = 2'd1,
        KIND_RESUME = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        LS_RUNNING  = 2'd0,
        LS_PARKED   = 2'd1,
        LS_WAITING  = 2'd2,
        LS_STUCK    = 2'd3
    } t_line_state;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_EVAL  = 2'd1,
        ST_SHIFT = 2'd2
    } t_state;

    typedef struct packed {
        logic [2:0]           command;
        logic [CHANNEL_W-1:0] channel;
        logic [CODE_W-1:0]    code;
    } t_in;

    typedef struct packed {
        logic [1:0]           kind;
        logic [CHANNEL_W-1:0] line_channel;
        logic [1:0]           line_state;
        logic [CODE_W-1:0]    reason;
        logic [TIME_W-1:0]    elapsed;
        logic                 last;
    } t_out;

    // Operation broadcast to every cell; addressed ops also need the cell's select.
    typedef struct packed {
        logic              do_tick;
        logic              do_reg;
        logic              do_unreg;
        logic              do_beat;
        logic              do_park;
        logic              do_wait;
        logic [CODE_W-1:0] code;
    } t_cell_op;

    // One report line travelling down the chain.
    typedef struct packed {
        logic                 valid;
        logic [CHANNEL_W-1:0] channel;
        logic [1:0]           state;
        logic [CODE_W-1:0]    reason;
        logic [TIME_W-1:0]    elapsed;
    } t_line;

endpackage

`default_nettype wire

@@ hw/rtl/hbwd_cell.sv @@
// ----------------------------------------------------------------------------
// hbwd_cell
// One watched channel: its record, its tick update and one slot of the
// report chain that shifts lines towards the output.
// ----------------------------------------------------------------------------
`default_nettype none

module hbwd_cell #(
    parameter int IDX = 0
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  hbwd_pkg::t_cell_op           i_op,
    input  wire                          i_sel,
    input  wire  [hbwd_pkg::TIME_W-1:0]  i_now,
    input  wire  [hbwd_pkg::TIME_W-1:0]  i_now_next,
    input  wire  [hbwd_pkg::CFG_W-1:0]   i_stall,
    input  wire                          i_load,
    input  wire                          i_shift,
    input  hbwd_pkg::t_line              i_next_slot,
    output hbwd_pkg::t_line              o_slot,
    output logic                         o_stalled
);
    import hbwd_pkg::*;

    logic              r_en, n_en;
    logic              r_beat, n_beat;
    logic [CODE_W-1:0] r_park, n_park;
    logic [CODE_W-1:0] r_wait, n_wait;
    logic [TIME_W-1:0] r_prog, n_prog;
    logic              r_stalled, n_stalled;
    t_line             r_slot, n_slot;
    t_line             line;
    logic [TIME_W-1:0] age_next;
    logic [TIME_W-1:0] age_now;

    assign age_next = i_now_next - r_prog;
    assign age_now  = i_now - r_prog;

    always_comb begin
        n_en      = r_en;
        n_beat    = r_beat;
        n_park    = r_park;
        n_wait    = r_wait;
        n_prog    = r_prog;
        n_stalled = r_stalled;
        if (i_op.do_tick) begin
            if (r_en) begin
                if (r_park != '0 || r_beat) begin
                    n_beat    = 1'b0;
                    n_prog    = i_now_next;
                    n_stalled = 1'b0;
                end else begin
                    n_stalled = age_next >= {{(TIME_W-CFG_W){1'b0}}, i_stall};
                end
            end
        end else if (i_sel) begin
            if (i_op.do_reg || i_op.do_unreg) begin
                n_en      = i_op.do_reg;
                n_beat    = 1'b0;
                n_park    = '0;
                n_wait    = '0;
                n_prog    = i_op.do_reg ? i_now : '0;
                n_stalled = 1'b0;
            end else if (r_en) begin
                if (i_op.do_beat) begin
                    n_beat = 1'b1;
                end
                if (i_op.do_park) begin
                    n_park = i_op.code;
                end
                if (i_op.do_wait) begin
                    n_wait = i_op.code;
                end
            end
        end
    end

    // Line this channel contributes to a report: parked over waiting over stalled.
    always_comb begin
        line         = '0;
        line.valid   = r_en;
        line.channel = CHANNEL_W'(IDX);
        if (r_park != '0) begin
            line.state  = LS_PARKED;
            line.reason = r_park;
        end else if (r_wait != '0) begin
            line.state   = LS_WAITING;
            line.reason  = r_wait;
            line.elapsed = age_now;
        end else if (r_stalled) begin
            line.state   = LS_STUCK;
            line.elapsed = age_now;
        end else begin
            line.state = LS_RUNNING;
        end
    end

    always_comb begin
        n_slot = r_slot;
        if (i_load) begin
            n_slot = line;
        end else if (i_shift) begin
            n_slot = i_next_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en      <= 1'b0;
            r_beat    <= 1'b0;
            r_park    <= '0;
            r_wait    <= '0;
            r_prog    <= '0;
            r_stalled <= 1'b0;
            r_slot    <= '0;
        end else begin
            r_en      <= n_en;
            r_beat    <= n_beat;
            r_park    <= n_park;
            r_wait    <= n_wait;
            r_prog    <= n_prog;
            r_stalled <= n_stalled;
            r_slot    <= n_slot;
        end
    end

    assign o_slot    = r_slot;
    assign o_stalled = r_stalled;

endmodule

`default_nettype wire

@@ hw/rtl/multi_channel_heartbeat_watchdog_unit.sv @@
// ----------------------------------------------------------------------------
// multi_channel_heartbeat_watchdog_unit
// Heartbeat watchdog over a row of channel cells with a shifting report chain.
// ----------------------------------------------------------------------------
// Usage:
//   Issue a command item with start while busy is low. Register, unregister,
//   beat and code commands complete in the accepting cycle and give no result;
//   the next item may follow at once.
//   A tick updates every cell in the accepting cycle, then holds busy through
//   an evaluation state. If nothing is reported the block is idle again after
//   evaluation. A resumed notice is on o_result in the cycle after evaluation.
//   A freeze report shows the header in the cycle after evaluation, then the
//   chain shifts one cell a cycle; the slot walk through the cell chain sets
//   the length of a report. Disabled channels leave gaps in the strobe.
//   Each result is on o_result for one cycle with o_strobe high; the receiver
//   cannot stall, and last marks the final result of the tick.
//   stall_ticks and repeat_ticks sit at APB byte addresses 0 and 4.
//   Reset clears every channel, the time base and the freeze state and loads
//   the register defaults (5 and 30); no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_channel_heartbeat_watchdog_unit #(
    parameter int CHANNELS = hbwd_pkg::CHANNELS_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          start,
    output logic                         busy,
    input  hbwd_pkg::t_in                i_item,
    output logic                         o_strobe,
    output hbwd_pkg::t_out               o_result,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire  [hbwd_pkg::APB_AW-1:0]  paddr,
    input  wire  [hbwd_pkg::APB_DW-1:0]  pwdata,
    output logic [hbwd_pkg::APB_DW-1:0]  prdata,
    output logic                         pready
);
    import hbwd_pkg::*;

    t_state            r_state, n_state;
    logic [CFG_W-1:0]  r_stall, n_stall;
    logic [CFG_W-1:0]  r_repeat, n_repeat;
    logic [TIME_W-1:0] r_now, n_now;
    logic              r_freeze, n_freeze;
    logic [TIME_W-1:0] r_fstart, n_fstart;
    logic [TIME_W-1:0] r_due, n_due;
    logic              r_strobe, n_strobe;
    t_out              r_result, n_result;

    logic              accept;
    logic              is_tick;
    t_cell_op          op;
    logic [TIME_W-1:0] now_next;
    logic              stall_seen;
    logic [TIME_W-1:0] due_lag;
    logic              report;
    logic              load_chain;
    logic              shift_chain;
    logic              rest_valid;
    logic              cfg_wr;

    logic [CHANNELS-1:0] sel;
    logic [CHANNELS-1:0] stalled;
    logic [CHANNELS-1:0] slot_valid;
    t_line               slot [CHANNELS];
    t_line               head;

    assign busy     = (r_state != ST_IDLE);
    assign accept   = start && !busy;
    assign is_tick  = (i_item.command == CMD_TICK);
    assign now_next = r_now + TIME_W'(1);

    // Decode the item into a broadcast operation.
    always_comb begin
        op      = '0;
        op.code = i_item.code;
        if (accept) begin
            unique case (t_cmd'(i_item.command))
                CMD_TICK:  op.do_tick  = 1'b1;
                CMD_REG:   op.do_reg   = 1'b1;
                CMD_UNREG: op.do_unreg = 1'b1;
                CMD_BEAT:  op.do_beat  = 1'b1;
                CMD_PARK:  op.do_park  = 1'b1;
                CMD_WAIT:  op.do_wait  = 1'b1;
                default: ;
            endcase
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < CHANNELS; gi++) begin : g_cell
            t_line next_slot;
            if (gi == CHANNELS - 1) begin : g_tail
                assign next_slot = '0;
            end else begin : g_link
                assign next_slot = slot[gi+1];
            end
            if (gi <= CH_MAX) begin : g_addr
                assign sel[gi] = (i_item.channel == CHANNEL_W'(gi));
            end else begin : g_noaddr
                assign sel[gi] = 1'b0;
            end

            hbwd_cell #(
                .IDX (gi)
            ) u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_op        (op),
                .i_sel       (sel[gi]),
                .i_now       (r_now),
                .i_now_next  (now_next),
                .i_stall     (r_stall),
                .i_load      (load_chain),
                .i_shift     (shift_chain),
                .i_next_slot (next_slot),
                .o_slot      (slot[gi]),
                .o_stalled   (stalled[gi])
            );
            assign slot_valid[gi] = slot[gi].valid;
        end
    endgenerate

    assign head       = slot[0];
    assign rest_valid = |(slot_valid >> 1);
    assign stall_seen = |stalled;
    // Repeat once the due time is reached, read as a wrap-aware difference.
    assign due_lag    = r_now - r_due;
    assign report     = stall_seen && (!r_freeze || !due_lag[TIME_W-1]);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (accept && is_tick) n_state = ST_EVAL;
            ST_EVAL:  n_state = report ? ST_SHIFT : ST_IDLE;
            ST_SHIFT: if (!rest_valid) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        load_chain  = 1'b0;
        shift_chain = 1'b0;
        unique case (r_state)
            ST_EVAL:  load_chain  = report;
            ST_SHIFT: shift_chain = 1'b1;
            default: ;
        endcase
    end

    // Freeze bookkeeping and the result register.
    always_comb begin
        n_now    = (accept && is_tick) ? now_next : r_now;
        n_freeze = r_freeze;
        n_fstart = r_fstart;
        n_due    = r_due;
        n_strobe = 1'b0;
        n_result = '0;
        if (r_state == ST_EVAL) begin
            if (report) begin
                if (!r_freeze) begin
                    n_freeze = 1'b1;
                    n_fstart = r_now - {{(TIME_W-CFG_W){1'b0}}, r_stall};
                end
                n_due            = r_now + {{(TIME_W-CFG_W){1'b0}}, r_repeat};
                n_strobe         = 1'b1;
                n_result.kind    = KIND_HEADER;
                n_result.elapsed = r_now - n_fstart;
            end else if (!stall_seen && r_freeze) begin
                n_freeze         = 1'b0;
                n_strobe         = 1'b1;
                n_result.kind    = KIND_RESUME;
                n_result.elapsed = r_now - r_fstart;
                n_result.last    = 1'b1;
            end
        end else if (r_state == ST_SHIFT) begin
            n_strobe              = head.valid;
            n_result.kind         = KIND_LINE;
            n_result.line_channel = head.channel;
            n_result.line_state   = head.state;
            n_result.reason       = head.reason;
            n_result.elapsed      = head.elapsed;
            n_result.last         = !rest_valid;
        end
    end

    // Register port: index taken from the word address.
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = paddr[2] ? {{(APB_DW-CFG_W){1'b0}}, r_repeat}
                             : {{(APB_DW-CFG_W){1'b0}}, r_stall};

    always_comb begin
        n_stall  = r_stall;
        n_repeat = r_repeat;
        if (cfg_wr) begin
            if (paddr[2]) begin
                n_repeat = pwdata[CFG_W-1:0];
            end else begin
                n_stall = pwdata[CFG_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_stall  <= STALL_TICKS_RST;
            r_repeat <= REPEAT_TICKS_RST;
            r_now    <= '0;
            r_freeze <= 1'b0;
            r_fstart <= '0;
            r_due    <= '0;
            r_strobe <= 1'b0;
            r_result <= '0;
        end else begin
            r_state  <= n_state;
            r_stall  <= n_stall;
            r_repeat <= n_repeat;
            r_now    <= n_now;
            r_freeze <= n_freeze;
            r_fstart <= n_fstart;
            r_due    <= n_due;
            r_strobe <= n_strobe;
            r_result <= n_result;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    // A result only ever follows a cycle of tick work.
    a_strobe_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_state != ST_IDLE))
        else $error("result without tick work");

    // Commands other than tick leave the block idle.
    a_cmd_no_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && !is_tick |=> r_state == ST_IDLE)
        else $error("non-tick command started work");

    // The final result of a tick coincides with the return to idle.
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.last |-> r_state == ST_IDLE)
        else $error("last result while still busy");

    // Freeze state changes only on evaluation.
    a_freeze_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_freeze) |-> $past(r_state == ST_EVAL))
        else $error("freeze flag moved outside evaluation");

endmodule

`default_nettype wire

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the multi-channel heartbeat watchdog unit. Commands
// go in through the start/busy handshake; every accepted item runs through a
// behavioural copy of the watchdog, and the freeze report lines and resumed
// notices it predicts are matched in order against the strobed results. The
// register port sets the stall and repeat limits between phases, with reads
// to confirm each value.
// ----------------------------------------------------------------------------

module tb;

    import hbwd_pkg::*;

    localparam int          NCH         = CHANNELS_DEF;
    localparam logic [2:0]  CMD_RSVD_LO = 3'd6;
    localparam logic [2:0]  CMD_RSVD_HI = 3'd7;
    localparam logic [APB_AW-1:0] ADDR_STALL  = 3'd0;
    localparam logic [APB_AW-1:0] ADDR_REPEAT = 3'd4;

    // ------------------------------------------------------------------------
    // Watchdog predictor and store of expected report lines
    // ------------------------------------------------------------------------
    class freeze_report_board;
        bit                enabled [NCH];
        bit                beat_seen [NCH];
        logic [CODE_W-1:0] park_code [NCH];
        logic [CODE_W-1:0] waiting_code [NCH];
        logic [TIME_W-1:0] progress_at [NCH];
        bit                stalled [NCH];
        logic [TIME_W-1:0] now_tick;
        bit                frozen;
        logic [TIME_W-1:0] freeze_from;
        logic [TIME_W-1:0] report_due;
        logic [CFG_W-1:0]  stall_lim;
        logic [CFG_W-1:0]  repeat_gap;
        t_out              burst [$];
        t_out              expected_lines [$];
        int                faults;

        function new();
            for (int c = 0; c < NCH; c++) drop_channel(c);
            now_tick    = '0;
            frozen      = 1'b0;
            freeze_from = '0;
            report_due  = '0;
            stall_lim   = STALL_TICKS_RST;
            repeat_gap  = REPEAT_TICKS_RST;
            faults      = 0;
        endfunction

        function void drop_channel(int c);
            enabled[c]      = 1'b0;
            beat_seen[c]    = 1'b0;
            park_code[c]    = '0;
            waiting_code[c] = '0;
            progress_at[c]  = '0;
            stalled[c]      = 1'b0;
        endfunction

        function void report_fault(string msg);
            faults++;
            if (faults <= 10) $display("%s", msg);
        endfunction

        function int pending();
            return expected_lines.size();
        endfunction

        function void add_line(t_kind k, int ch, t_line_state st,
                               logic [CODE_W-1:0] rsn, logic [TIME_W-1:0] el);
            t_out r;
            r              = '0;
            r.kind         = k;
            r.line_channel = ch[CHANNEL_W-1:0];
            r.line_state   = st;
            r.reason       = rsn;
            r.elapsed      = el;
            burst.insert(burst.size(), r);
        endfunction

        function void freeze_report();
            add_line(KIND_HEADER, 0, LS_RUNNING, '0, now_tick - freeze_from);
            for (int c = 0; c < NCH; c++) begin
                if (!enabled[c]) continue;
                if (park_code[c] != 0)
                    add_line(KIND_LINE, c, LS_PARKED, park_code[c], '0);
                else if (waiting_code[c] != 0)
                    add_line(KIND_LINE, c, LS_WAITING, waiting_code[c],
                             now_tick - progress_at[c]);
                else if (stalled[c])
                    add_line(KIND_LINE, c, LS_STUCK, '0, now_tick - progress_at[c]);
                else
                    add_line(KIND_LINE, c, LS_RUNNING, '0, '0);
            end
        endfunction

        function void scan_tick();
            bit                any_stall;
            logic [TIME_W-1:0] lag;
            any_stall = 1'b0;
            now_tick  = now_tick + 1;
            for (int c = 0; c < NCH; c++) begin
                if (!enabled[c]) continue;
                if (park_code[c] != 0 || beat_seen[c]) begin
                    beat_seen[c]   = 1'b0;
                    progress_at[c] = now_tick;
                    stalled[c]     = 1'b0;
                    continue;
                end
                stalled[c] = (now_tick - progress_at[c]) >= {16'd0, stall_lim};
                if (stalled[c]) any_stall = 1'b1;
            end
            if (any_stall) begin
                lag = now_tick - report_due;
                if (!frozen) begin
                    frozen      = 1'b1;
                    freeze_from = now_tick - {16'd0, stall_lim};
                    report_due  = now_tick + {16'd0, repeat_gap};
                    freeze_report();
                end else if (!lag[TIME_W-1]) begin
                    report_due = now_tick + {16'd0, repeat_gap};
                    freeze_report();
                end
            end else if (frozen) begin
                frozen = 1'b0;
                add_line(KIND_RESUME, 0, LS_RUNNING, '0, now_tick - freeze_from);
            end
        endfunction

        function void note_command(t_in it);
            int ch;
            t_out r;
            ch = it.channel;
            burst.delete();
            case (it.command)
                CMD_TICK:  scan_tick();
                CMD_REG: begin
                    drop_channel(ch);
                    enabled[ch]     = 1'b1;
                    progress_at[ch] = now_tick;
                end
                CMD_UNREG: drop_channel(ch);
                CMD_BEAT:  if (enabled[ch]) beat_seen[ch] = 1'b1;
                CMD_PARK:  if (enabled[ch]) park_code[ch] = it.code;
                CMD_WAIT:  if (enabled[ch]) waiting_code[ch] = it.code;
                default: ;
            endcase
            for (int i = 0; i < burst.size(); i++) begin
                r      = burst[i];
                r.last = (i == burst.size() - 1);
                expected_lines.insert(expected_lines.size(), r);
            end
        endfunction

        function void check_line(t_out got);
            t_out want;
            if (expected_lines.size() == 0) begin
                report_fault($sformatf("unexpected result: kind=%0d ch=%0d state=%0d reason=%h elapsed=%h last=%b",
                    got.kind, got.line_channel, got.line_state, got.reason,
                    got.elapsed, got.last));
                return;
            end
            want = expected_lines.pop_front();
            if (got.kind !== want.kind || got.line_channel !== want.line_channel ||
                got.line_state !== want.line_state || got.reason !== want.reason ||
                got.elapsed !== want.elapsed || got.last !== want.last)
                report_fault($sformatf(
                    "result mismatch: expected kind=%0d ch=%0d state=%0d reason=%h elapsed=%h last=%b, got kind=%0d ch=%0d state=%0d reason=%h elapsed=%h last=%b",
                    want.kind, want.line_channel, want.line_state, want.reason,
                    want.elapsed, want.last, got.kind, got.line_channel,
                    got.line_state, got.reason, got.elapsed, got.last));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT and signals
    // ------------------------------------------------------------------------
    logic                 i_clk   = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start   = 1'b0;
    logic                 busy;
    t_in                  i_item  = '0;
    logic                 o_strobe;
    t_out                 o_result;
    logic                 psel    = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite  = 1'b0;
    logic [APB_AW-1:0]    paddr   = '0;
    logic [APB_DW-1:0]    pwdata  = '0;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;

    freeze_report_board sb;

    multi_channel_heartbeat_watchdog_unit #(.CHANNELS(NCH)) uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_strobe (o_strobe),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) sb.check_line(o_result);
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    task automatic send_item(t_in it);
        @(negedge i_clk);
        start  = 1'b1;
        i_item = it;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        sb.note_command(it);
    endtask

    task automatic send_cmd(logic [2:0] cmd, int ch, logic [CODE_W-1:0] code);
        t_in it;
        it.command = cmd;
        it.channel = ch[CHANNEL_W-1:0];
        it.code    = code;
        send_item(it);
    endtask

    // hold start low for a geometric run of cycles
    task automatic sender_gap(int pct);
        while ($urandom_range(99) < pct) begin
            @(negedge i_clk);
            start  = 1'b0;
            i_item = 14'($urandom);
        end
    endtask

    // drop start and wait until every expected item has come out
    task automatic settle();
        @(negedge i_clk);
        start = 1'b0;
        forever begin
            @(posedge i_clk);
            if (sb.pending() == 0 && !busy) break;
        end
        repeat (NCH + 2) @(posedge i_clk);
    endtask

    task automatic reg_write(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        forever begin
            @(posedge i_clk);
            if (pready) break;
        end
        if (addr == ADDR_STALL) sb.stall_lim = data[CFG_W-1:0];
        else sb.repeat_gap = data[CFG_W-1:0];
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic reg_read(logic [APB_AW-1:0] addr, logic [CFG_W-1:0] want);
        logic [APB_DW-1:0] got;
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = addr;
        @(negedge i_clk);
        penable = 1'b1;
        forever begin
            @(posedge i_clk);
            if (pready) break;
        end
        got = prdata;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        if (got[CFG_W-1:0] !== want)
            sb.report_fault($sformatf("register %0d readback: expected %h, got %h",
                                      addr, want, got));
    endtask

    task automatic set_limits(logic [CFG_W-1:0] stall, logic [CFG_W-1:0] rep);
        settle();
        reg_write(ADDR_STALL, {16'd0, stall});
        reg_write(ADDR_REPEAT, {16'd0, rep});
        reg_read(ADDR_STALL, stall);
        reg_read(ADDR_REPEAT, rep);
    endtask

    function automatic t_in random_item();
        t_in it;
        int  r;
        r          = $urandom_range(99);
        it.channel = CHANNEL_W'($urandom);
        it.code    = ($urandom_range(1) == 0) ? '0 : CODE_W'($urandom);
        if (r < 45)      it.command = CMD_TICK;
        else if (r < 58) it.command = CMD_BEAT;
        else if (r < 67) it.command = CMD_REG;
        else if (r < 72) it.command = CMD_UNREG;
        else if (r < 82) it.command = CMD_PARK;
        else if (r < 92) it.command = CMD_WAIT;
        else if (r < 96) it.command = CMD_RSVD_LO;
        else             it.command = CMD_RSVD_HI;
        return it;
    endfunction

    // mostly random commands, with heartbeat rounds that let freezes clear
    task automatic run_random(int count, int pct);
        int  sent;
        t_in it;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(99) < 15) begin
                for (int c = 0; c < NCH; c++) begin
                    if ($urandom_range(3) != 0) begin
                        send_cmd(CMD_BEAT, c, CODE_W'($urandom));
                        sender_gap(pct);
                        sent++;
                    end
                end
                send_cmd(CMD_TICK, 0, '0);
                sender_gap(pct);
                sent++;
            end else begin
                it = random_item();
                send_item(it);
                sender_gap(pct);
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        sb = new();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        reg_read(ADDR_STALL, STALL_TICKS_RST);
        reg_read(ADDR_REPEAT, REPEAT_TICKS_RST);

        // register, codes, ignored commands on idle channels and reserved codes
        send_cmd(CMD_REG, 0, '0);
        send_cmd(CMD_REG, 3, '0);
        send_cmd(CMD_REG, 7, 8'hff);
        send_cmd(CMD_PARK, 7, 8'hff);
        send_cmd(CMD_WAIT, 3, 8'h01);
        send_cmd(CMD_BEAT, 5, '0);
        send_cmd(CMD_RSVD_LO, 1, 8'h55);
        send_cmd(CMD_RSVD_HI, 2, 8'haa);
        send_cmd(CMD_PARK, 2, 8'haa);
        // run into the first freeze report
        repeat (5) send_cmd(CMD_TICK, 0, '0);
        send_cmd(CMD_BEAT, 0, '0);
        send_cmd(CMD_TICK, 0, '0);
        // clear the freeze for a resumed notice
        send_cmd(CMD_UNREG, 3, '0);
        send_cmd(CMD_TICK, 0, '0);
        // re-register an enabled channel, then clear codes
        send_cmd(CMD_REG, 0, '0);
        send_cmd(CMD_WAIT, 0, 8'hff);
        send_cmd(CMD_WAIT, 0, 8'h00);
        send_cmd(CMD_PARK, 7, 8'h00);
        send_cmd(CMD_TICK, 7, 8'hff);

        run_random(40, 0);

        set_limits(16'd1, 16'd1);
        run_random(40, 79);

        set_limits(16'd3, 16'd0);
        run_random(15, 0);
        settle();
        run_random(15, 0);

        set_limits(16'd0, 16'hffff);
        run_random(30, 13);

        set_limits(16'hffff, 16'd2);
        run_random(25, 79);

        set_limits(16'd8, 16'd5);
        run_random(30, 13);

        settle();
        if (sb.pending() != 0)
            sb.report_fault($sformatf("%0d expected results never arrived", sb.pending()));
        if (sb.faults == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
